FILE: rtl/core/assert_macros.svh
// Assertion helpers included by extendible_hash_table_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define EHT_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that implies another at the same clock edge.
`define EHT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/eht_pkg.sv
`default_nettype none
package eht_pkg;
   localparam int DEPTH_CAP = 8;
   localparam int SLOTS = 8;
   localparam int SLOT_BITS = 3;
   localparam int DIR_SIZE = 256;
   localparam int DIR_BITS = 8;
   localparam int KEY_BITS = 31;
   localparam int PAY_BITS = 32;
   localparam int SLOT_W = KEY_BITS + PAY_BITS;
   localparam int SLOT_DEPTH = DIR_SIZE * SLOTS;
   localparam int META_W = 8;
   localparam int TID_BITS = 12;
   localparam int CNT_BITS = DIR_BITS + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [10:0] {
      S_IDLE       = 11'b00000000001,
      S_CLEAR      = 11'b00000000010,
      S_DIR        = 11'b00000000100,
      S_META       = 11'b00000001000,
      S_DECIDE     = 11'b00000010000,
      S_SPLIT_DIR  = 11'b00000100000,
      S_SPLIT_SLOT = 11'b00001000000,
      S_SPLIT_OLD  = 11'b00010000000,
      S_SPLIT_NEW  = 11'b00100000000,
      S_DOUBLE     = 11'b01000000000,
      S_SCAN       = 11'b10000000000
   } state_type;

   // Per-bucket record: local depth and number of used slots.
   typedef struct packed {
      logic [3:0] ld;
      logic [3:0] fill;
   } meta_type;
endpackage
`default_nettype wire

FILE: rtl/core/extendible_hash_table_top.sv
`default_nettype none
// Insert without a split: directory read, bucket record read, then slot and record write. Lookup:
// the last beat comes as the scan ends when nothing matches, in the cycle after on a match.
// A split walks the directory, then the bucket's slots, and writes both bucket records; a
// doubling copies the lower half of the directory. Both then restart at the directory read.
// One item at a time. Clear sweeps all 256 entries; after reset the same sweep runs, busy high.
// Each result is shown for one cycle on rsp_strobe; the receiver cannot stall.
module extendible_hash_table_top import eht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [30:0] req_key,
   input  wire logic [31:0] req_payload,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_tuple_id,
   output logic [31:0]      rsp_found_payload,
   output logic             rsp_last
);
`include "assert_macros.svh"

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0] op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [PAY_BITS-1:0] pay_ff, pay_in;
   logic [DIR_BITS-1:0] bkt_ff, bkt_in, nb_ff, nb_in;
   logic [3:0] ld_ff, ld_in, fill_ff, fill_in, keep_ff, keep_in, move_ff, move_in;
   logic [3:0] gd_ff, gd_in, init_ff, init_in;
   logic [CNT_BITS-1:0] bcount_ff, bcount_in;
   logic pend_ff, pend_in;
   logic [TID_BITS-1:0] pend_tid_ff, pend_tid_in;
   logic [PAY_BITS-1:0] pend_pay_ff, pend_pay_in;
   logic rsp_strobe_ff, rsp_strobe_in, rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [TID_BITS-1:0] rsp_tid_ff, rsp_tid_in;
   logic [PAY_BITS-1:0] rsp_pay_ff, rsp_pay_in;

   logic dir_we, meta_we, slot_we;
   logic [DIR_BITS-1:0] dir_wa, dir_wd, dir_ra, dir_rd, meta_wa, meta_ra;
   meta_type meta_wd, meta_rd;
   logic [$clog2(SLOT_DEPTH)-1:0] slot_wa, slot_ra;
   logic [SLOT_W-1:0] slot_wd, slot_rd;

   logic [CNT_BITS-1:0] size9, half9, dmask9;
   logic [DIR_BITS-1:0] prev;
   logic [3:0] clamp_d;
   logic slot_match;

   eht_ram #(.WIDTH(DIR_BITS), .DEPTH(DIR_SIZE)) u_dir (
      .clock(clock), .wr_en(dir_we), .wr_addr(dir_wa), .wr_data(dir_wd),
      .rd_addr(dir_ra), .rd_data(dir_rd)
   );
   eht_ram #(.WIDTH(META_W), .DEPTH(DIR_SIZE)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_addr(meta_ra), .rd_data(meta_rd)
   );
   eht_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ra), .rd_data(slot_rd)
   );

   // Depth-derived sizes and the walk index of the entry whose read data has arrived.
   assign size9  = CNT_BITS'(1) << gd_ff;
   assign half9  = CNT_BITS'(1) << (gd_ff - 4'd1);
   assign dmask9 = size9 - CNT_BITS'(1);
   assign prev   = DIR_BITS'(cnt_ff - CNT_BITS'(1));
   assign slot_match = (slot_rd[SLOT_W-1:PAY_BITS] == key_ff);

   always_comb begin
      if (init_ff == 4'd0) begin
         clamp_d = 4'd1;
      end else if (init_ff > 4'(DEPTH_CAP)) begin
         clamp_d = 4'(DEPTH_CAP);
      end else begin
         clamp_d = init_ff;
      end
   end

   // Read addresses follow the state; the registered read data returns in the next cycle.
   always_comb begin
      dir_ra  = (state_ff == S_DIR) ? (key_ff[DIR_BITS-1:0] & dmask9[DIR_BITS-1:0])
                                    : cnt_ff[DIR_BITS-1:0];
      meta_ra = dir_rd;
      slot_ra = {bkt_ff, cnt_ff[SLOT_BITS-1:0]};
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;     cnt_in = cnt_ff;       op_in = op_ff;
      key_in = key_ff;         pay_in = pay_ff;       bkt_in = bkt_ff;
      nb_in = nb_ff;           ld_in = ld_ff;         fill_in = fill_ff;
      keep_in = keep_ff;       move_in = move_ff;     gd_in = gd_ff;
      init_in = csr_wr_en ? csr_wr_data : init_ff;
      bcount_in = bcount_ff;   pend_in = pend_ff;
      pend_tid_in = pend_tid_ff; pend_pay_in = pend_pay_ff;
      rsp_strobe_in = 1'b0;    rsp_status_in = rsp_status_ff;
      rsp_tid_in = rsp_tid_ff; rsp_pay_in = rsp_pay_ff; rsp_last_in = rsp_last_ff;
      dir_we = 1'b0;  dir_wa = prev;  dir_wd = nb_ff;
      meta_we = 1'b0; meta_wa = bkt_ff; meta_wd = '0;
      slot_we = 1'b0; slot_wa = {bkt_ff, keep_ff[SLOT_BITS-1:0]}; slot_wd = slot_rd;

      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               op_in = req_operation;
               key_in = req_key;
               pay_in = req_payload;
               cnt_in = '0;
               if (req_operation == OP_CLEAR) begin
                  gd_in = clamp_d;
                  bcount_in = CNT_BITS'(1) << (clamp_d - 4'd1);
                  state_in = S_CLEAR;
               end else if (req_operation == OP_INSERT || req_operation == OP_LOOKUP) begin
                  state_in = S_DIR;
               end
            end
         end
         S_CLEAR: begin
            // Rebuild one directory entry and one bucket record per cycle.
            dir_we = 1'b1;
            dir_wa = cnt_ff[DIR_BITS-1:0];
            dir_wd = cnt_ff[DIR_BITS-1:0] & (half9[DIR_BITS-1:0] - DIR_BITS'(1));
            meta_we = 1'b1;
            meta_wa = cnt_ff[DIR_BITS-1:0];
            meta_wd.ld = (cnt_ff < half9) ? (gd_ff - 4'd1) : 4'd0;
            meta_wd.fill = 4'd0;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff[DIR_BITS-1:0] == DIR_BITS'(DIR_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_DIR: begin
            state_in = S_META;
         end
         S_META: begin
            bkt_in = dir_rd;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ld_in = meta_rd.ld;
            fill_in = meta_rd.fill;
            cnt_in = '0;
            pend_in = 1'b0;
            keep_in = '0;
            move_in = '0;
            if (op_ff == OP_LOOKUP) begin
               state_in = S_SCAN;
            end else if (meta_rd.fill < 4'(SLOTS)) begin
               slot_we = 1'b1;
               slot_wa = {bkt_ff, meta_rd.fill[SLOT_BITS-1:0]};
               slot_wd = {key_ff, pay_ff};
               meta_we = 1'b1;
               meta_wd.ld = meta_rd.ld;
               meta_wd.fill = meta_rd.fill + 4'd1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_INSERTED;
               rsp_tid_in = {CNT_BITS'(bkt_ff) + CNT_BITS'(1), meta_rd.fill[SLOT_BITS-1:0]};
               rsp_pay_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end else if (meta_rd.ld < gd_ff) begin
               nb_in = bcount_ff[DIR_BITS-1:0];
               bcount_in = bcount_ff + CNT_BITS'(1);
               state_in = S_SPLIT_DIR;
            end else if (gd_ff < 4'(DEPTH_CAP)) begin
               state_in = S_DOUBLE;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_tid_in = '0;
               rsp_pay_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SPLIT_DIR: begin
            // Redirect entries of the old bucket whose split bit is set.
            if (cnt_ff != '0 && dir_rd == bkt_ff && prev[ld_ff[2:0]]) begin
               dir_we = 1'b1;
            end
            if (cnt_ff == size9) begin
               cnt_in = '0;
               state_in = S_SPLIT_SLOT;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         S_SPLIT_SLOT: begin
            // Redistribute slots; writes land only on slots already read.
            if (cnt_ff != '0) begin
               slot_we = 1'b1;
               if (slot_rd[PAY_BITS + 32'(ld_ff)]) begin
                  slot_wa = {nb_ff, move_ff[SLOT_BITS-1:0]};
                  move_in = move_ff + 4'd1;
               end else begin
                  keep_in = keep_ff + 4'd1;
               end
            end
            if (cnt_ff[3:0] == fill_ff) begin
               state_in = S_SPLIT_OLD;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         S_SPLIT_OLD: begin
            meta_we = 1'b1;
            meta_wd.ld = ld_ff + 4'd1;
            meta_wd.fill = keep_ff;
            state_in = S_SPLIT_NEW;
         end
         S_SPLIT_NEW: begin
            meta_we = 1'b1;
            meta_wa = nb_ff;
            meta_wd.ld = ld_ff + 4'd1;
            meta_wd.fill = move_ff;
            state_in = S_DIR;
         end
         S_DOUBLE: begin
            // Copy the lower half of the directory into the upper half.
            if (cnt_ff != '0) begin
               dir_we = 1'b1;
               dir_wa = prev | size9[DIR_BITS-1:0];
               dir_wd = dir_rd;
            end
            if (cnt_ff == size9) begin
               gd_in = gd_ff + 4'd1;
               state_in = S_DIR;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         S_SCAN: begin
            // Hold one match back so the final beat can carry last.
            if (cnt_ff != '0 && slot_match) begin
               if (pend_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_FOUND;
                  rsp_tid_in = pend_tid_ff;
                  rsp_pay_in = pend_pay_ff;
                  rsp_last_in = 1'b0;
               end
               pend_in = 1'b1;
               pend_tid_in = {CNT_BITS'(bkt_ff) + CNT_BITS'(1), prev[SLOT_BITS-1:0]};
               pend_pay_in = slot_rd[PAY_BITS-1:0];
            end
            if (cnt_ff[3:0] == fill_ff) begin
               state_in = S_IDLE;
               cnt_in = '0;
               op_in = OP_NONE;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Closing beat of a lookup, in the cycle after the scan ends.
      if (state_ff == S_IDLE && op_ff == OP_NONE && pend_ff == 1'b1) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = ST_FOUND;
         rsp_tid_in = pend_tid_ff;
         rsp_pay_in = pend_pay_ff;
         rsp_last_in = 1'b1;
         pend_in = 1'b0;
      end else if (state_ff == S_IDLE && op_ff == OP_NONE && !start) begin
         op_in = OP_NONE;
      end
      if (state_ff == S_SCAN && cnt_ff[3:0] == fill_ff && !pend_in) begin
         // No match at all: report not found directly.
         rsp_strobe_in = 1'b1;
         rsp_status_in = ST_NOT_FOUND;
         rsp_tid_in = '0;
         rsp_pay_in = '0;
         rsp_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         op_ff <= OP_INSERT;
         gd_ff <= 4'd1;
         init_ff <= 4'd1;
         bcount_ff <= CNT_BITS'(1);
         pend_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
         gd_ff <= gd_in;
         init_ff <= init_in;
         bcount_ff <= bcount_in;
         pend_ff <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      key_ff <= key_in;       pay_ff <= pay_in;       bkt_ff <= bkt_in;
      nb_ff <= nb_in;         ld_ff <= ld_in;         fill_ff <= fill_in;
      keep_ff <= keep_in;     move_ff <= move_in;
      pend_tid_ff <= pend_tid_in; pend_pay_ff <= pend_pay_in;
      rsp_status_ff <= rsp_status_in; rsp_tid_ff <= rsp_tid_in;
      rsp_pay_ff <= rsp_pay_in; rsp_last_ff <= rsp_last_in;
   end

   // The closing lookup beat is pending while idle, so busy covers it too.
   assign busy = (state_ff != S_IDLE) || (op_ff == OP_NONE && pend_ff);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_tuple_id = rsp_tid_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_last = rsp_last_ff;

   `EHT_ASSERT(a_depth_range, (gd_ff >= 4'd1) && (gd_ff <= 4'(DEPTH_CAP)), "depth out of range")
   `EHT_IMPLY(a_fill_bound, state_ff == S_DECIDE, meta_rd.fill <= 4'(SLOTS), "bucket overfilled")
   `EHT_IMPLY(a_split_depth, state_ff == S_SPLIT_DIR, ld_ff < gd_ff, "split at full depth")
   `EHT_IMPLY(a_bucket_count, state_ff == S_IDLE, bcount_ff <= CNT_BITS'(DIR_SIZE), "too many buckets")
endmodule
`default_nettype wire

FILE: rtl/core/eht_ram.sv
`default_nettype none
module eht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
